FILE: sv/cfd_pkg.sv
// Shared types and constants for the callsign frame decoder.
// Used by callsign_frame_decoder_unit; depends on nothing else.
`default_nettype none

package cfd_pkg;

   localparam int unsigned MaxCallsign = 8;
   localparam int unsigned MaxFrame    = 255;
   localparam int unsigned QueueDepth  = 4;

   typedef enum logic [1:0] {
      KIND_FID    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CALLSIGN = 2'd1,
      ST_INVALID  = 2'd2,
      ST_LENGTH   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_CALLSIGN_CHARS = 1'b0,
      CSR_CALLSIGN_LEN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      status_type status;
      logic       last;
   } result_type;

endpackage : cfd_pkg

`default_nettype wire

FILE: sv/callsign_frame_decoder_unit.sv
// Callsign frame decoder: parses frames byte by byte and emits results.
// Depends on cfd_pkg for result types, codes and constants.
//
// Usage: frame bytes enter on the req_ channel (valid/stall), one byte per
// transfer, with req_in_last marking the final byte. Each byte is decoded in
// the cycle it is accepted and its results (function ID, data byte and, on
// the final byte, an end-of-frame status) are written into a four-entry
// result queue that drives the rsp_ channel. Results reach rsp_ only from the
// registered queue, never straight from the decode. One byte can be accepted every cycle;
// req_stall rises only when the queue holds more than two results, so the
// rate is one byte per cycle as long as the result side keeps up with the
// results produced (up to two per byte on the final byte of a frame).
// When the receiver stalls, the head result holds steady and the queue
// fills until input is stalled. Reset empties the queue, restarts frame
// parsing and sets the expected callsign to zero with a length of one.
// The csr_ port writes the callsign (index 0) and its length (index 1);
// writes are meant to happen only while no frame is in progress.
`default_nettype none

module callsign_frame_decoder_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [7:0]             req_in_byte,
   input  wire logic                   req_in_last,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      cfd_pkg::kind_type      rsp_out_kind,
   output      logic [7:0]             rsp_out_byte,
   output      cfd_pkg::status_type    rsp_frame_status,
   output      logic                   rsp_out_last,
   input  wire logic                   csr_wr_en,
   input  wire cfd_pkg::csr_index_type csr_index,
   input  wire logic [63:0]            csr_wdata
);
   import cfd_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   logic [7:0][7:0] chars_ff;
   logic [3:0]      cs_len_ff;

   logic [7:0] pos_ff,  pos_in;
   logic       bad_ff,  bad_in;
   logic [7:0] len_ff,  len_in;
   logic       over_ff, over_in;

   result_type            queue_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;

   logic       accept;
   logic       pop;
   logic [3:0] used_len;
   logic [7:0] used_len8;
   logic [7:0] count_bytes;
   logic       at_end;
   logic       cs_bad_now;
   logic       over_now;
   logic       emit_byte;
   kind_type   byte_kind;
   status_type status;
   result_type res0, res1;
   logic [1:0] push_num;

   always_comb begin
      used_len = cs_len_ff;
      if (cs_len_ff == 4'd0) begin
         used_len = 4'd1;
      end else if (cs_len_ff > 4'(MaxCallsign)) begin
         used_len = 4'(MaxCallsign);
      end
   end
   assign used_len8 = {4'd0, used_len};

   assign req_stall = (count_ff > (PtrWidth+1)'(QueueDepth - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   // Per-byte decode and the next frame state.
   always_comb begin
      at_end     = (pos_ff >= 8'(MaxFrame));
      over_now   = over_ff || at_end;
      cs_bad_now = bad_ff;
      len_in     = len_ff;
      emit_byte  = 1'b0;
      byte_kind  = KIND_DATA;
      pos_in     = pos_ff;
      if (!at_end) begin
         if (pos_ff < used_len8) begin
            if (chars_ff[pos_ff[2:0]] != req_in_byte) begin
               cs_bad_now = 1'b1;
            end
         end else if (pos_ff == used_len8) begin
            emit_byte = 1'b1;
            byte_kind = KIND_FID;
         end else if (pos_ff == used_len8 + 8'd1) begin
            len_in = req_in_byte;
         end else begin
            emit_byte = 1'b1;
            byte_kind = KIND_DATA;
         end
         pos_in = pos_ff + 8'd1;
      end
      count_bytes = pos_in;

      if (over_now || (count_bytes < used_len8 + 8'd1)) begin
         status = ST_INVALID;
      end else if (cs_bad_now) begin
         status = ST_CALLSIGN;
      end else if (count_bytes == used_len8 + 8'd1) begin
         status = ST_OK;
      end else if (len_in != (count_bytes - used_len8 - 8'd2)) begin
         status = ST_LENGTH;
      end else begin
         status = ST_OK;
      end

      bad_in  = cs_bad_now;
      over_in = over_now;
      if (req_in_last) begin
         pos_in  = 8'd0;
         bad_in  = 1'b0;
         len_in  = 8'd0;
         over_in = 1'b0;
      end
   end

   // Results of this byte, in delivery order.
   always_comb begin
      res0     = '{kind: KIND_STATUS, data: 8'd0, status: status, last: 1'b1};
      res1     = res0;
      push_num = 2'd0;
      if (emit_byte) begin
         res0     = '{kind: byte_kind, data: req_in_byte, status: ST_OK,
                      last: !req_in_last};
         push_num = req_in_last ? 2'd2 : 2'd1;
      end else if (req_in_last) begin
         push_num = 2'd1;
      end
      if (!accept) begin
         push_num = 2'd0;
      end
   end

   assign wr_ptr_in = wr_ptr_ff + PtrWidth'(push_num);
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + (PtrWidth+1)'(push_num) - (PtrWidth+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 8'd0;
         bad_ff    <= 1'b0;
         len_ff    <= 8'd0;
         over_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         chars_ff  <= '0;
         cs_len_ff <= 4'd1;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            bad_ff  <= bad_in;
            len_ff  <= len_in;
            over_ff <= over_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CALLSIGN_CHARS: chars_ff  <= csr_wdata;
               CSR_CALLSIGN_LEN:   cs_len_ff <= csr_wdata[3:0];
               default:            chars_ff  <= chars_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_num == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrWidth'(1)] <= res1;
      end
   end

   assign rsp_out_kind     = queue_ff[rd_ptr_ff].kind;
   assign rsp_out_byte     = queue_ff[rd_ptr_ff].data;
   assign rsp_frame_status = queue_ff[rd_ptr_ff].status;
   assign rsp_out_last     = queue_ff[rd_ptr_ff].last;

endmodule : callsign_frame_decoder_unit

`default_nettype wire
